FILE: hdl/rme_pkg.sv
// ----------------------------------------------------------------------------
// rme_pkg
// Types and codes shared by the register machine execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rme_pkg;

    localparam logic [3:0] MODE_ADD  = 4'd0;
    localparam logic [3:0] MODE_MOVE = 4'd1;
    localparam logic [3:0] MODE_SUB  = 4'd2;
    localparam logic [3:0] MODE_MULT = 4'd3;
    localparam logic [3:0] MODE_DIV  = 4'd4;
    localparam logic [3:0] MODE_AND  = 4'd5;
    localparam logic [3:0] MODE_OR   = 4'd6;
    localparam logic [3:0] MODE_BEQ  = 4'd7;
    localparam logic [3:0] MODE_BNE  = 4'd8;
    localparam logic [3:0] MODE_LW   = 4'd9;
    localparam logic [3:0] MODE_SW   = 4'd10;
    localparam logic [3:0] MODE_J    = 4'd11;
    localparam logic [3:0] MODE_LI   = 4'd12;

    localparam logic [31:0] PC_STEP  = 32'd4;
    localparam int          WORD_W   = 32;
    localparam int          ITER_W   = 5;

    typedef struct packed {
        logic        [3:0]  mode;
        logic        [4:0]  dest_reg;
        logic        [4:0]  src_a_reg;
        logic        [4:0]  src_b_reg;
        logic signed [31:0] branch_offset;
        logic signed [31:0] load_value;
        logic        [8:0]  mem_address;
    } t_in;

    typedef struct packed {
        logic        [31:0] pc_after;
        logic signed [31:0] written_value;
        logic               branch_taken;
        logic               div_by_zero;
    } t_out;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_A,
        S_RD_B,
        S_RD_D,
        S_PC,
        S_OP,
        S_MUL,
        S_DNA,
        S_DNB,
        S_DIV,
        S_DSGN,
        S_CMP,
        S_BR,
        S_SW,
        S_WB,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

FILE: hdl/rme_ram.sv
// ----------------------------------------------------------------------------
// rme_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: hdl/register_machine_execute_unit.sv
// ----------------------------------------------------------------------------
// register_machine_execute_unit
// Executes one decoded instruction per item against a register file, a word
// data memory and a program counter, using one shared 32-bit adder.
// ----------------------------------------------------------------------------
//
//  channel   | valid        | ready        | payload
//  ----------+--------------+--------------+-------------------------
//  input     | i_in_valid   | o_in_ready   | i_in_data  (t_in)
//  output    | o_out_valid  | i_out_ready  | o_out_data (t_out)
//
//  Each item: S_RD_A, S_RD_B, S_RD_D, S_PC, then S_OP, S_WB (add, move, sub,
//  and, or, lw, li); S_MUL with 32 shift-add steps, S_WB (mult); S_DNA, S_DNB,
//  S_DIV with 32 restoring steps, S_DSGN, S_WB (div); S_CMP, S_BR if taken
//  (beq/bne); S_SW (sw); S_BR (j); div by zero goes to S_DONE. Reset clears
//  register valid bits; then data memory is swept to zero with o_in_ready low.
//  A finished item waits in the output register; the next item may be
//  accepted while it waits, but the following result stalls until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module register_machine_execute_unit #(
    parameter int NUM_REGS    = 32,
    parameter int MEM_WORDS   = 512,
    parameter int LOGIC_WIDTH = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire rme_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output rme_pkg::t_out      o_out_data
);

    localparam int          RF_AW      = $clog2(NUM_REGS);
    localparam int          MEM_AW     = $clog2(MEM_WORDS);
    localparam logic [31:0] NUM_REGS_W = 32'(NUM_REGS);
    localparam logic [31:0] MEM_WORDS_W = 32'(MEM_WORDS);
    localparam logic [31:0] LOGIC_MASK = 32'((64'd1 << LOGIC_WIDTH) - 64'd1);
    localparam logic [MEM_AW-1:0] CLR_LAST = MEM_AW'(MEM_WORDS - 1);
    localparam logic [rme_pkg::ITER_W-1:0] ITER_LAST = '1;

    rme_pkg::t_state r_state, n_state;
    rme_pkg::t_in    r_in, n_in;
    rme_pkg::t_out   r_out, n_out;
    logic            r_out_vld, n_out_vld;

    logic [31:0] r_a, n_a;
    logic [31:0] r_b, n_b;
    logic [31:0] r_d, n_d;
    logic [31:0] r_m, n_m;
    logic [31:0] r_pc, n_pc;
    logic [31:0] r_wv, n_wv;
    logic [31:0] r_x, n_x;
    logic [31:0] r_y, n_y;
    logic [31:0] r_rem, n_rem;
    logic        r_neg, n_neg;
    logic        r_taken, n_taken;
    logic        r_dz, n_dz;
    logic [rme_pkg::ITER_W-1:0] r_cnt, n_cnt;
    logic [MEM_AW-1:0]          r_clr, n_clr;
    logic [NUM_REGS-1:0]        r_rf_vld;
    logic [4:0]                 r_rsel;

    // shared adder
    logic [31:0] alu_x, alu_y;
    logic        alu_sub;
    logic [32:0] alu_res;
    logic [31:0] alu_sum;
    logic        alu_cout;

    assign alu_res  = {1'b0, alu_x} + {1'b0, (alu_sub ? ~alu_y : alu_y)} + 33'(alu_sub);
    assign alu_sum  = alu_res[31:0];
    assign alu_cout = alu_res[32];

    // register file and data memory
    logic             rf_we;
    logic [RF_AW-1:0] rf_waddr, rf_raddr;
    logic [31:0]      rf_rdata;
    logic [4:0]       rf_rsel;
    logic             rf_rok;
    logic [31:0]      rf_val;
    logic             mem_we;
    logic [MEM_AW-1:0] mem_waddr, mem_raddr, mem_idx;
    logic [31:0]      mem_wdata, mem_rdata;
    logic [31:0]      addr_ext;
    logic             mem_ok;
    logic             rd_ok;
    logic [31:0]      div_shift;

    rme_ram #(.WIDTH(rme_pkg::WORD_W), .DEPTH(NUM_REGS)) u_rf (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (r_wv),
        .i_raddr (rf_raddr),
        .o_rdata (rf_rdata)
    );

    rme_ram #(.WIDTH(rme_pkg::WORD_W), .DEPTH(MEM_WORDS)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign addr_ext  = 32'(r_in.mem_address);
    assign mem_idx   = addr_ext[MEM_AW-1:0];
    assign mem_ok    = addr_ext < MEM_WORDS_W;
    assign mem_raddr = mem_idx;
    assign rd_ok     = (32'(r_in.dest_reg) < NUM_REGS_W) && (r_in.dest_reg != 5'd0);
    assign rf_waddr  = r_in.dest_reg[RF_AW-1:0];
    assign rf_raddr  = rf_rsel[RF_AW-1:0];
    assign div_shift = {r_rem[30:0], r_y[31]};

    // valid bit of the entry whose read data arrives this cycle
    always_comb begin
        rf_rok = (32'(r_rsel) < NUM_REGS_W) && r_rf_vld[r_rsel[RF_AW-1:0]];
        rf_val = rf_rok ? rf_rdata : '0;
    end

    assign o_in_ready  = (r_state == rme_pkg::S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rme_pkg::S_CLEAR;
            r_out_vld <= 1'b0;
            r_pc      <= '0;
            r_cnt     <= '0;
            r_clr     <= '0;
            r_rf_vld  <= '0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_pc      <= n_pc;
            r_cnt     <= n_cnt;
            r_clr     <= n_clr;
            if (rf_we) begin
                r_rf_vld[rf_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_in    <= n_in;
        r_out   <= n_out;
        r_a     <= n_a;
        r_b     <= n_b;
        r_d     <= n_d;
        r_m     <= n_m;
        r_wv    <= n_wv;
        r_x     <= n_x;
        r_y     <= n_y;
        r_rem   <= n_rem;
        r_neg   <= n_neg;
        r_taken <= n_taken;
        r_dz    <= n_dz;
        r_rsel  <= rf_rsel;
    end

    always_comb begin
        n_state   = r_state;
        n_in      = r_in;
        n_out     = r_out;
        n_out_vld = r_out_vld && !i_out_ready;
        n_a       = r_a;
        n_b       = r_b;
        n_d       = r_d;
        n_m       = r_m;
        n_pc      = r_pc;
        n_wv      = r_wv;
        n_x       = r_x;
        n_y       = r_y;
        n_rem     = r_rem;
        n_neg     = r_neg;
        n_taken   = r_taken;
        n_dz      = r_dz;
        n_cnt     = r_cnt;
        n_clr     = r_clr;
        alu_x     = r_pc;
        alu_y     = rme_pkg::PC_STEP;
        alu_sub   = 1'b0;
        rf_we     = 1'b0;
        rf_rsel   = r_in.src_a_reg;
        mem_we    = 1'b0;
        mem_waddr = mem_idx;
        mem_wdata = r_d;

        unique case (r_state)
            rme_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == CLR_LAST) begin
                    n_state = rme_pkg::S_IDLE;
                end
            end
            rme_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in_data;
                    n_state = rme_pkg::S_RD_A;
                end
            end
            rme_pkg::S_RD_A: begin
                rf_rsel = r_in.src_a_reg;
                n_state = rme_pkg::S_RD_B;
            end
            rme_pkg::S_RD_B: begin
                rf_rsel = r_in.src_b_reg;
                n_a     = rf_val;
                n_state = rme_pkg::S_RD_D;
            end
            rme_pkg::S_RD_D: begin
                rf_rsel = r_in.dest_reg;
                n_b     = rf_val;
                n_state = rme_pkg::S_PC;
            end
            rme_pkg::S_PC: begin
                n_d     = rf_val;
                n_m     = mem_ok ? mem_rdata : '0;
                n_pc    = alu_sum;
                n_wv    = '0;
                n_taken = 1'b0;
                n_dz    = 1'b0;
                unique case (r_in.mode)
                    rme_pkg::MODE_ADD, rme_pkg::MODE_MOVE, rme_pkg::MODE_SUB,
                    rme_pkg::MODE_AND, rme_pkg::MODE_OR, rme_pkg::MODE_LW,
                    rme_pkg::MODE_LI: begin
                        n_state = rme_pkg::S_OP;
                    end
                    rme_pkg::MODE_MULT: begin
                        n_x     = r_a;
                        n_y     = r_b;
                        n_cnt   = '0;
                        n_state = rme_pkg::S_MUL;
                    end
                    rme_pkg::MODE_DIV: begin
                        if (r_b == '0) begin
                            n_dz    = 1'b1;
                            n_state = rme_pkg::S_DONE;
                        end else begin
                            n_state = rme_pkg::S_DNA;
                        end
                    end
                    rme_pkg::MODE_BEQ, rme_pkg::MODE_BNE: begin
                        n_state = rme_pkg::S_CMP;
                    end
                    rme_pkg::MODE_SW: begin
                        n_state = rme_pkg::S_SW;
                    end
                    rme_pkg::MODE_J: begin
                        n_state = rme_pkg::S_BR;
                    end
                    default: begin
                        n_state = rme_pkg::S_DONE;
                    end
                endcase
            end
            rme_pkg::S_OP: begin
                alu_x   = r_a;
                alu_y   = r_b;
                alu_sub = (r_in.mode == rme_pkg::MODE_SUB);
                unique case (r_in.mode)
                    rme_pkg::MODE_ADD,
                    rme_pkg::MODE_SUB:  n_wv = alu_sum;
                    rme_pkg::MODE_MOVE: n_wv = r_a;
                    rme_pkg::MODE_AND:  n_wv = (r_a & r_b) & LOGIC_MASK;
                    rme_pkg::MODE_OR:   n_wv = (r_a | r_b) & LOGIC_MASK;
                    rme_pkg::MODE_LW:   n_wv = r_m;
                    default:            n_wv = r_in.load_value;
                endcase
                n_state = rme_pkg::S_WB;
            end
            rme_pkg::S_MUL: begin
                alu_x = r_wv;
                alu_y = r_x;
                if (r_y[0]) begin
                    n_wv = alu_sum;
                end
                n_x   = {r_x[30:0], 1'b0};
                n_y   = {1'b0, r_y[31:1]};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == ITER_LAST) begin
                    n_state = rme_pkg::S_WB;
                end
            end
            rme_pkg::S_DNA: begin
                alu_x   = '0;
                alu_y   = r_a;
                alu_sub = 1'b1;
                n_y     = r_a[31] ? alu_sum : r_a;
                n_neg   = r_a[31] ^ r_b[31];
                n_state = rme_pkg::S_DNB;
            end
            rme_pkg::S_DNB: begin
                alu_x   = '0;
                alu_y   = r_b;
                alu_sub = 1'b1;
                n_x     = r_b[31] ? alu_sum : r_b;
                n_rem   = '0;
                n_cnt   = '0;
                n_state = rme_pkg::S_DIV;
            end
            rme_pkg::S_DIV: begin
                // remainder stays below the divisor, so the shifted value fits
                alu_x   = div_shift;
                alu_y   = r_x;
                alu_sub = 1'b1;
                n_rem   = alu_cout ? alu_sum : div_shift;
                n_y     = {r_y[30:0], alu_cout};
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt == ITER_LAST) begin
                    n_state = rme_pkg::S_DSGN;
                end
            end
            rme_pkg::S_DSGN: begin
                alu_x   = '0;
                alu_y   = r_y;
                alu_sub = 1'b1;
                n_wv    = r_neg ? alu_sum : r_y;
                n_state = rme_pkg::S_WB;
            end
            rme_pkg::S_CMP: begin
                alu_x   = r_d;
                alu_y   = r_a;
                alu_sub = 1'b1;
                if ((alu_sum == '0) == (r_in.mode == rme_pkg::MODE_BEQ)) begin
                    n_state = rme_pkg::S_BR;
                end else begin
                    n_state = rme_pkg::S_DONE;
                end
            end
            rme_pkg::S_BR: begin
                alu_x   = r_pc;
                alu_y   = r_in.branch_offset;
                n_pc    = alu_sum;
                n_taken = 1'b1;
                n_state = rme_pkg::S_DONE;
            end
            rme_pkg::S_SW: begin
                mem_we  = mem_ok;
                n_wv    = r_d;
                n_state = rme_pkg::S_DONE;
            end
            rme_pkg::S_WB: begin
                rf_we   = rd_ok;
                n_state = rme_pkg::S_DONE;
            end
            rme_pkg::S_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    n_out.pc_after      = r_pc;
                    n_out.written_value = r_wv;
                    n_out.branch_taken  = r_taken;
                    n_out.div_by_zero   = r_dz;
                    n_out_vld           = 1'b1;
                    n_state             = rme_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rme_pkg::S_IDLE;
            end
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_rf_vld[0])
        else $error("register 0 marked as written");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rme_pkg::S_CLEAR) |-> !r_out_vld)
        else $error("result present during memory clear");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == rme_pkg::S_RD_A))
        else $error("accepted item did not start register reads");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rme_pkg::S_DIV) |-> (r_x != '0))
        else $error("division running with zero divisor");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rme_pkg::S_DONE && r_out_vld && !i_out_ready)
            |=> (r_state == rme_pkg::S_DONE))
        else $error("result dropped while output stalled");

endmodule

`default_nettype wire
